@@ src/strip_cluster_centroid_macros.svh @@
// ----------------------------------------------------------------------------
// strip_cluster_centroid assertion macros
// Immediate-consequence and next-cycle implication checks.
// ----------------------------------------------------------------------------
`ifndef STRIP_CLUSTER_CENTROID_MACROS_SVH
`define STRIP_CLUSTER_CENTROID_MACROS_SVH

// same-cycle implication
`define SCC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SCC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/scc_pkg.sv @@
// ----------------------------------------------------------------------------
// scc_pkg
// Field widths, status codes and shared types of the strip cluster centroid.
// ----------------------------------------------------------------------------
`default_nettype none

package scc_pkg;

   localparam int STRIP_ADC_W   = 10;
   localparam int FIRST_STRIP_W = 10;
   localparam int CENTROID_W    = 19;
   localparam int STATUS_W      = 2;

   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ZERO = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_LONG = 2'd2;

   typedef struct packed {
      logic full;
      logic empty;
   } scc_q_status_type;

endpackage

`default_nettype wire

@@ src/scc_if.sv @@
// ----------------------------------------------------------------------------
// scc_if
// Valid/ready channels for strip requests and centroid responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface scc_req_if import scc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [STRIP_ADC_W-1:0]   strip_adc;
   logic [FIRST_STRIP_W-1:0] first_strip;
   logic                     last;

   modport source (output valid, strip_adc, first_strip, last, input ready);
   modport sink   (input valid, strip_adc, first_strip, last, output ready);
endinterface

interface scc_rsp_if import scc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CENTROID_W-1:0] centroid;
   logic [STATUS_W-1:0]   status;

   modport source (output valid, centroid, status, input ready);
   modport sink   (input valid, centroid, status, output ready);
endinterface

`default_nettype wire

@@ src/scc_front.sv @@
// ----------------------------------------------------------------------------
// scc_front
// Accepts one strip per cycle while the job queue has room, keeps the charge
// and weighted sums and hands a finished cluster to it on the last strip.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_front import scc_pkg::*; #(
   parameter int MAX_WIDTH = 16,
   parameter int ADC_BITS  = 10,
   parameter int IDX_W     = 10,
   parameter int OFF_W     = 5,
   parameter int WSUM_W    = 17,
   parameter int CSUM_W    = 14
) (
   input  wire logic             clock,
   input  wire logic             reset,
   scc_req_if.sink               req,
   input  wire scc_q_status_type q_stat,
   output logic                  job_push,
   output logic [WSUM_W-1:0]     job_wsum,
   output logic [CSUM_W-1:0]     job_csum,
   output logic [IDX_W-1:0]      job_base,
   output logic                  job_long
);

   localparam int ADC_USE = (ADC_BITS < STRIP_ADC_W) ? ADC_BITS : STRIP_ADC_W;

   logic [OFF_W-1:0]  offset_ff, offset_in;
   logic [WSUM_W-1:0] wsum_ff, wsum_in;
   logic [CSUM_W-1:0] csum_ff, csum_in;
   logic [IDX_W-1:0]  base_ff, base_in;
   logic              long_ff, long_in;

   logic                      accept;
   logic                      start;
   logic                      in_range;
   logic [ADC_BITS-1:0]       adc;
   logic [ADC_BITS+OFF_W-1:0] prod;
   logic [WSUM_W-1:0]         w_base;
   logic [CSUM_W-1:0]         c_base;
   logic                      l_base;

   assign req.ready = !q_stat.full;
   assign accept    = req.valid && req.ready;

   always_comb begin
      adc      = ADC_BITS'(req.strip_adc[ADC_USE-1:0]);
      start    = (offset_ff == '0);
      in_range = (offset_ff < OFF_W'(MAX_WIDTH));
      w_base   = start ? '0 : wsum_ff;
      c_base   = start ? '0 : csum_ff;
      l_base   = start ? 1'b0 : long_ff;
      base_in  = start ? req.first_strip[IDX_W-1:0] : base_ff;
      prod     = (ADC_BITS+OFF_W)'(adc) * (ADC_BITS+OFF_W)'(offset_ff);
      if (in_range) begin
         wsum_in   = w_base + WSUM_W'(prod);
         csum_in   = c_base + CSUM_W'(adc);
         offset_in = offset_ff + OFF_W'(1);
         long_in   = l_base;
      end else begin
         wsum_in   = w_base;
         csum_in   = c_base;
         offset_in = offset_ff;
         long_in   = 1'b1;
      end
   end

   assign job_push = accept && req.last;
   assign job_wsum = wsum_in;
   assign job_csum = csum_in;
   assign job_base = base_in;
   assign job_long = long_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
      end else if (accept) begin
         offset_ff <= req.last ? '0 : offset_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         wsum_ff <= wsum_in;
         csum_ff <= csum_in;
         base_ff <= base_in;
         long_ff <= long_in;
      end
   end

endmodule

`default_nettype wire

@@ src/scc_queue.sv @@
// ----------------------------------------------------------------------------
// scc_queue
// Two-entry job queue between the accumulating front and the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_queue import scc_pkg::*; #(
   parameter int DATA_W = 42
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic [DATA_W-1:0] push_data,
   input  wire logic              pop,
   output logic [DATA_W-1:0]      pop_data,
   output scc_q_status_type       stat
);

   localparam int DEPTH = 2;

   logic [DATA_W-1:0] entry_ff [DEPTH];
   logic              wr_ff, wr_in;
   logic              rd_ff, rd_in;
   logic [1:0]        cnt_ff, cnt_in;

   always_comb begin
      wr_in  = push ? !wr_ff : wr_ff;
      rd_in  = pop  ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   assign stat.full  = (cnt_ff == 2'(DEPTH));
   assign stat.empty = (cnt_ff == 2'd0);
   assign pop_data   = entry_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

@@ src/scc_div.sv @@
// ----------------------------------------------------------------------------
// scc_div
// Back end: restoring divider, one quotient bit per cycle, then the base
// strip offset and status, held in the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_div import scc_pkg::*; #(
   parameter int WSUM_W    = 17,
   parameter int CSUM_W    = 14,
   parameter int IDX_W     = 10,
   parameter int FRAC_BITS = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire scc_q_status_type q_stat,
   input  wire logic [WSUM_W-1:0] job_wsum,
   input  wire logic [CSUM_W-1:0] job_csum,
   input  wire logic [IDX_W-1:0]  job_base,
   input  wire logic              job_long,
   output logic                  q_pop,
   scc_rsp_if.source             rsp
);

   localparam int N      = WSUM_W + FRAC_BITS;
   localparam int CNT_W  = $clog2(N + 1);
   localparam int IDXF_W = IDX_W + FRAC_BITS;
   localparam int SUM_W  = ((IDXF_W > N) ? IDXF_W : N) + 1;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  valid_ff, valid_in;
   logic [N-1:0]          dvd_ff, dvd_in;
   logic [CSUM_W-1:0]     rem_ff, rem_in;
   logic [CSUM_W-1:0]     csum_ff;
   logic [IDX_W-1:0]      base_ff;
   logic                  long_ff;
   logic [CENTROID_W-1:0] centroid_ff, centroid_in;
   logic [STATUS_W-1:0]   status_ff, status_in;

   logic              out_free;
   logic              load_out;
   logic [CSUM_W:0]   trial;
   logic              ge;
   logic [CSUM_W:0]   diff;
   logic [SUM_W-1:0]  pos;

   assign out_free = !valid_ff || rsp.ready;
   assign q_pop    = (state_ff == ST_IDLE) && !q_stat.empty;
   assign load_out = (state_ff == ST_DONE) && out_free;

   always_comb begin
      trial  = {rem_ff, dvd_ff[N-1]};
      ge     = (trial >= {1'b0, csum_ff});
      diff   = trial - {1'b0, csum_ff};
      rem_in = ge ? diff[CSUM_W-1:0] : trial[CSUM_W-1:0];
      dvd_in = {dvd_ff[N-2:0], ge};
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               state_in = ST_RUN;
               cnt_in   = CNT_W'(N);
            end
         end
         ST_RUN: begin
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      pos = (SUM_W'(base_ff) << FRAC_BITS) + SUM_W'(dvd_ff);
      centroid_in = (csum_ff == '0) ? '0 : CENTROID_W'(pos);
      priority if (long_ff) begin
         status_in = STATUS_LONG;
      end else if (csum_ff == '0) begin
         status_in = STATUS_ZERO;
      end else begin
         status_in = STATUS_OK;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (load_out) begin
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         dvd_ff  <= N'(job_wsum) << FRAC_BITS;
         rem_ff  <= '0;
         csum_ff <= job_csum;
         base_ff <= job_base;
         long_ff <= job_long;
      end else if (state_ff == ST_RUN) begin
         dvd_ff <= dvd_in;
         rem_ff <= rem_in;
      end
      if (load_out) begin
         centroid_ff <= centroid_in;
         status_ff   <= status_in;
      end
   end

   assign rsp.valid    = valid_ff;
   assign rsp.centroid = centroid_ff;
   assign rsp.status   = status_ff;

endmodule

`default_nettype wire

@@ src/strip_cluster_centroid.sv @@
// ----------------------------------------------------------------------------
// strip_cluster_centroid
// Charge-weighted centroid of a strip cluster, fixed point, truncated.
//
//   channel    dir  handshake              carries
//   req_chan   in   valid/ready            strip_adc, first_strip, last
//   rsp_chan   out  valid/ready            centroid, status (one per cluster)
//
// The front takes one strip per cycle while the job queue has room.
// The divider takes one cluster at a time, one quotient bit per cycle;
// the two-entry queue buffers finished clusters.
// The response register holds a result until taken; the divider waits on it.
// Synchronous reset clears the strip count, queue pointers and handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module strip_cluster_centroid import scc_pkg::*; #(
   parameter int MAX_WIDTH        = 16,
   parameter int ADC_BITS         = 10,
   parameter int FRAC_BITS        = 8,
   parameter int STRIP_INDEX_BITS = 10
) (
   input wire logic clock,
   input wire logic reset,
   scc_req_if.sink   req_chan,
   scc_rsp_if.source rsp_chan
);

`include "strip_cluster_centroid_macros.svh"

   localparam int IDX_W  = (STRIP_INDEX_BITS < FIRST_STRIP_W) ?
                           STRIP_INDEX_BITS : FIRST_STRIP_W;
   localparam int OFF_W  = $clog2(MAX_WIDTH + 1);
   localparam int CSUM_W = ADC_BITS + $clog2(MAX_WIDTH + 1);
   localparam int WSUM_W = ADC_BITS + $clog2((MAX_WIDTH * (MAX_WIDTH - 1)) / 2 + 1);
   localparam int JOB_W  = WSUM_W + CSUM_W + IDX_W + 1;

   scc_q_status_type  q_stat;
   logic              job_push;
   logic [WSUM_W-1:0] push_wsum, pop_wsum;
   logic [CSUM_W-1:0] push_csum, pop_csum;
   logic [IDX_W-1:0]  push_base, pop_base;
   logic              push_long, pop_long;
   logic [JOB_W-1:0]  push_data, pop_data;
   logic              q_pop;

   scc_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .ADC_BITS  (ADC_BITS),
      .IDX_W     (IDX_W),
      .OFF_W     (OFF_W),
      .WSUM_W    (WSUM_W),
      .CSUM_W    (CSUM_W)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_chan),
      .q_stat   (q_stat),
      .job_push (job_push),
      .job_wsum (push_wsum),
      .job_csum (push_csum),
      .job_base (push_base),
      .job_long (push_long)
   );

   assign push_data = {push_wsum, push_csum, push_base, push_long};

   scc_queue #(
      .DATA_W (JOB_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (push_data),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .stat      (q_stat)
   );

   assign {pop_wsum, pop_csum, pop_base, pop_long} = pop_data;

   scc_div #(
      .WSUM_W    (WSUM_W),
      .CSUM_W    (CSUM_W),
      .IDX_W     (IDX_W),
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .q_stat   (q_stat),
      .job_wsum (pop_wsum),
      .job_csum (pop_csum),
      .job_base (pop_base),
      .job_long (pop_long),
      .q_pop    (q_pop),
      .rsp      (rsp_chan)
   );

   `SCC_ASSERT_IMP(a_no_overflow, clock, reset, job_push, !q_stat.full, "push into full queue")
   `SCC_ASSERT_IMP(a_no_underflow, clock, reset, q_pop, !q_stat.empty, "pop from empty queue")
   `SCC_ASSERT_NXT(a_div_busy, clock, reset, q_pop, !q_pop, "divider popped twice in a row")
   `SCC_ASSERT_IMP(a_zero_charge, clock, reset,
      rsp_chan.valid && rsp_chan.status == STATUS_ZERO, rsp_chan.centroid == '0,
      "nonzero centroid on zero charge")

endmodule

`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Strip cluster centroid testbench. A negedge driver sends strip requests from
// a queue filled by the stimulus process, and a posedge monitor runs every
// accepted strip through a cycle-free centroid predictor. Each response is
// checked field by field against the oldest predicted centroid. Both
// channels idle at random, except for a steady window with no idling.
// ----------------------------------------------------------------------------
module tb;
   import scc_pkg::*;

   localparam int STRIP_LIMIT  = 16;
   localparam int FRAC         = 8;
   localparam int IDLE_PCT     = 32;
   localparam int STEADY_START = 3000;
   localparam int STEADY_END   = 5000;
   localparam int RANDOM_ITEMS = 1700;
   localparam int DRAIN_CYCLES = 80;
   localparam int CYCLE_LIMIT  = 600000;

   typedef enum int {ADC_RANDOM, ADC_ZERO, ADC_FULL, ADC_SPARSE, ADC_LOW} adc_mode_type;

   typedef struct packed {
      logic [STRIP_ADC_W-1:0]   strip_adc;
      logic [FIRST_STRIP_W-1:0] first_strip;
      logic                     last;
   } strip_type;

   typedef struct packed {
      logic [CENTROID_W-1:0] centroid;
      logic [STATUS_W-1:0]   status;
   } centroid_type;

   logic clock;
   logic reset;

   scc_req_if req_chan ();
   scc_rsp_if rsp_chan ();

   strip_cluster_centroid i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   strip_type    strip_q[$];
   centroid_type centroid_q[$];
   strip_type    next_strip;

   // predictor state
   logic [16:0] weighted_sum;
   logic [13:0] charge_sum;
   logic [4:0]  strip_offset;
   logic [9:0]  base_strip;
   bit          too_long;

   int  cycle_count;
   int  total_strips;
   int  accepted_strips;
   int  error_count;
   int  result_count;
   int  zero_count;
   int  long_count;
   bit  req_taken;
   bit  steady;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.strip_adc   = '0;
      req_chan.first_strip = '0;
      req_chan.last        = 1'b0;
      rsp_chan.ready       = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      error_count++;
      $display("mismatch @%0d: %s got %0d expected %0d", cycle_count, what, got, want);
   endtask

   task automatic predict_strip(input strip_type s);
      centroid_type expected;
      longint       pos;
      if (strip_offset == 0) begin
         weighted_sum = '0;
         charge_sum   = '0;
         too_long     = 1'b0;
         base_strip   = s.first_strip;
      end
      if (strip_offset < STRIP_LIMIT) begin
         weighted_sum = weighted_sum + 17'(s.strip_adc) * 17'(strip_offset);
         charge_sum   = charge_sum + 14'(s.strip_adc);
         strip_offset = strip_offset + 5'd1;
      end else begin
         too_long = 1'b1;
      end
      if (s.last) begin
         pos = 0;
         if (charge_sum != 0)
            pos = (longint'(base_strip) << FRAC)
                + ((longint'(weighted_sum) << FRAC) / longint'(charge_sum));
         expected.centroid = pos[CENTROID_W-1:0];
         if (too_long)
            expected.status = STATUS_LONG;
         else if (charge_sum == 0)
            expected.status = STATUS_ZERO;
         else
            expected.status = STATUS_OK;
         centroid_q.push_back(expected);
         weighted_sum = '0;
         charge_sum   = '0;
         strip_offset = '0;
         base_strip   = '0;
         too_long     = 1'b0;
      end
   endtask

   task automatic push_strip(input int adc, input int first, input bit last);
      strip_type s;
      s.strip_adc   = adc[STRIP_ADC_W-1:0];
      s.first_strip = first[FIRST_STRIP_W-1:0];
      s.last        = last;
      strip_q.push_back(s);
      total_strips++;
   endtask

   task automatic queue_cluster(input int len, input adc_mode_type mode);
      int adc;
      int first;
      for (int i = 0; i < len; i++) begin
         case (mode)
            ADC_ZERO:   adc = 0;
            ADC_FULL:   adc = 1023;
            ADC_SPARSE: adc = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : 0;
            ADC_LOW:    adc = $urandom_range(0, 15);
            default:    adc = $urandom_range(0, 1023);
         endcase
         case ($urandom_range(0, 7))
            0:       first = 0;
            1:       first = 1023;
            default: first = $urandom_range(0, 1023);
         endcase
         push_strip(adc, first, i == len - 1);
      end
   endtask

   // monitor: requests are predicted before responses of the same edge
   always @(posedge clock) begin
      centroid_type want;
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAIL");
         $finish;
      end
      req_taken <= !reset && req_chan.valid && req_chan.ready;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            accepted_strips++;
            predict_strip({req_chan.strip_adc, req_chan.first_strip, req_chan.last});
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            result_count++;
            if (centroid_q.size() == 0) begin
               report_mismatch("unexpected response, centroid", rsp_chan.centroid, -1);
            end else begin
               want = centroid_q.pop_front();
               if (rsp_chan.centroid !== want.centroid)
                  report_mismatch("centroid", rsp_chan.centroid, want.centroid);
               if (rsp_chan.status !== want.status)
                  report_mismatch("status", rsp_chan.status, want.status);
               if (want.status == STATUS_ZERO) zero_count++;
               if (want.status == STATUS_LONG) long_count++;
            end
         end
      end
   end

   // driver
   always @(negedge clock) begin
      steady = (cycle_count >= STEADY_START) && (cycle_count < STEADY_END);
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_taken) begin
         if (strip_q.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
            next_strip = strip_q.pop_front();
            req_chan.valid       <= 1'b1;
            req_chan.strip_adc   <= next_strip.strip_adc;
            req_chan.first_strip <= next_strip.first_strip;
            req_chan.last        <= next_strip.last;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
      rsp_chan.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   initial begin
      cycle_count     = 0;
      total_strips    = 0;
      accepted_strips = 0;
      error_count     = 0;
      result_count    = 0;
      zero_count      = 0;
      long_count      = 0;
      weighted_sum    = '0;
      charge_sum      = '0;
      strip_offset    = '0;
      base_strip      = '0;
      too_long        = 1'b0;

      // directed: zero charge, full-scale single strip, ignored first_strip,
      // overlong cluster at full scale
      push_strip(0, 0, 1'b1);
      push_strip(1023, 1023, 1'b1);
      push_strip(0, 512, 1'b0);
      push_strip(1023, 5, 1'b1);
      for (int i = 0; i < STRIP_LIMIT + 1; i++)
         push_strip(1023, 1023 - i, i == STRIP_LIMIT);

      while (total_strips < RANDOM_ITEMS + 21) begin
         int           r;
         int           len;
         adc_mode_type mode;
         r = $urandom_range(0, 99);
         if (r < 10)
            len = $urandom_range(STRIP_LIMIT + 1, STRIP_LIMIT + 8);
         else if (r < 25)
            len = 1;
         else
            len = $urandom_range(2, STRIP_LIMIT);
         case ($urandom_range(0, 9))
            0:       mode = ADC_ZERO;
            1:       mode = ADC_FULL;
            2, 3:    mode = ADC_SPARSE;
            4:       mode = ADC_LOW;
            default: mode = ADC_RANDOM;
         endcase
         queue_cluster(len, mode);
      end

      while (accepted_strips < total_strips || centroid_q.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("%0d strip requests, %0d centroids checked", accepted_strips, result_count);
      $display("%0d zero-charge and %0d overlong clusters, %0d mismatches",
               zero_count, long_count, error_count);
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
